// File: rtl/b64d_pkg.sv
// Shared types, constants and character classification for the base64 decoder.
`timescale 1ns / 1ps
package b64d_pkg;

    localparam int unsigned JOB_QUEUE_DEPTH = 4;
    localparam int unsigned SEXTET_W        = 6;
    localparam int unsigned STORE_W         = 3 * SEXTET_W;
    localparam int unsigned GROUP_W         = 4 * SEXTET_W;

    localparam logic [1:0] CNT_FULL = 2'd3;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_string;
    } char_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_data;
        logic       last_of_string;
        logic       stopped_early;
    } result_item_t;

    // One decode job: up to three bytes, left aligned in word.
    typedef struct packed {
        logic [GROUP_W-1:0] word;
        logic [1:0]         nbytes;
        logic               last;
        logic               stopped;
    } job_t;

    // Return {invalid, sextet}; invalid covers '=' and every non-alphabet code.
    function automatic logic [SEXTET_W:0] sextet_of(input logic [7:0] c);
        logic [SEXTET_W:0] r;
        r = {1'b1, {SEXTET_W{1'b0}}};
        case (c) inside
            [8'h41:8'h5A]: r = {1'b0, 6'(c - 8'h41)};
            [8'h61:8'h7A]: r = {1'b0, 6'(c - 8'h61 + 8'd26)};
            [8'h30:8'h39]: r = {1'b0, 6'(c - 8'h30 + 8'd52)};
            8'h2B:         r = {1'b0, 6'd62};
            8'h2F:         r = {1'b0, 6'd63};
            default:       r = {1'b1, {SEXTET_W{1'b0}}};
        endcase
        return r;
    endfunction

    // Left-align a partial group for flushing.
    function automatic logic [GROUP_W-1:0] flush_word(input logic [STORE_W-1:0] store,
                                                      input logic [1:0] cnt);
        logic [GROUP_W-1:0] w;
        w = '0;
        case (cnt)
            CNT_FULL: w = {store, {SEXTET_W{1'b0}}};
            CNT_TWO:  w = {store[2*SEXTET_W-1:0], {2*SEXTET_W{1'b0}}};
            default:  w = '0;
        endcase
        return w;
    endfunction

    // A partial group of n values yields n-1 bytes; a single value yields none.
    function automatic logic [1:0] flush_count(input logic [1:0] cnt);
        logic [1:0] n;
        case (cnt)
            CNT_FULL: n = 2'd2;
            CNT_TWO:  n = 2'd1;
            default:  n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

// File: rtl/b64d_front.sv
// Front end: accepts characters, tracks the group state and builds decode jobs.
`timescale 1ns / 1ps
module b64d_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  b64d_pkg::char_item_t char_item,
    input  logic                q_full,
    output logic                job_push,
    output b64d_pkg::job_t      job
);
    import b64d_pkg::*;

    logic [STORE_W-1:0] store_reg, store_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic               halted_reg, halted_next;

    logic               accept;
    logic [SEXTET_W:0]  cls;
    logic [STORE_W-1:0] st1;
    logic [1:0]         cnt1;
    logic               halt1;
    logic [GROUP_W-1:0] cw;
    logic [1:0]         cn;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign cls    = sextet_of(char_item.char_code);

    always_comb
    begin
        st1   = store_reg;
        cnt1  = cnt_reg;
        halt1 = halted_reg;
        cw    = '0;
        cn    = 2'd0;
        if (!halted_reg)
        begin
            if (!cls[SEXTET_W])
            begin
                if (cnt_reg == CNT_FULL)
                begin
                    cw   = {store_reg, cls[SEXTET_W-1:0]};
                    cn   = 2'd3;
                    st1  = '0;
                    cnt1 = 2'd0;
                end
                else
                begin
                    st1  = {store_reg[STORE_W-SEXTET_W-1:0], cls[SEXTET_W-1:0]};
                    cnt1 = 2'(cnt_reg + 2'd1);
                end
            end
            else
            begin
                // Pad or invalid character: flush what is held and stop.
                cw    = flush_word(store_reg, cnt_reg);
                cn    = flush_count(cnt_reg);
                st1   = '0;
                cnt1  = 2'd0;
                halt1 = 1'b1;
            end
        end

        job.word    = cw;
        job.nbytes  = cn;
        job.last    = char_item.end_of_string;
        job.stopped = halt1;
        if (char_item.end_of_string && (cn == 2'd0))
        begin
            job.word   = flush_word(st1, cnt1);
            job.nbytes = flush_count(cnt1);
        end

        job_push = accept && ((job.nbytes != 2'd0) || char_item.end_of_string);

        store_next  = store_reg;
        cnt_next    = cnt_reg;
        halted_next = halted_reg;
        if (accept)
        begin
            if (char_item.end_of_string)
            begin
                store_next  = '0;
                cnt_next    = 2'd0;
                halted_next = 1'b0;
            end
            else
            begin
                store_next  = st1;
                cnt_next    = cnt1;
                halted_next = halt1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg  <= '0;
            cnt_reg    <= 2'd0;
            halted_reg <= 1'b0;
        end
        else
        begin
            store_reg  <= store_next;
            cnt_reg    <= cnt_next;
            halted_reg <= halted_next;
        end
    end

endmodule

// File: rtl/b64d_queue.sv
// Small job queue between the front end and the byte emitter.
`timescale 1ns / 1ps
module b64d_queue #(
    parameter int unsigned DEPTH = b64d_pkg::JOB_QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  b64d_pkg::job_t wr_data,
    output logic           q_full,
    input  logic           rd_en,
    output b64d_pkg::job_t rd_data,
    output logic           q_empty
);
    import b64d_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign q_full  = (count_reg == DEPTH_CNT);
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/b64d_back.sv
// Back end: splits each job into result items and holds them in an output register.
`timescale 1ns / 1ps
module b64d_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  b64d_pkg::job_t         q_data,
    output logic                   q_pop,
    input  logic                   pop,
    output logic                   empty,
    output b64d_pkg::result_item_t result_item
);
    import b64d_pkg::*;

    job_t         job_reg;
    logic         job_valid_reg;
    logic [1:0]   idx_reg;
    result_item_t out_reg;
    logic         out_valid_reg;

    logic         load;
    logic         at_end;
    logic         finish;
    logic [7:0]   cur_byte;
    result_item_t cur_item;

    assign empty       = !out_valid_reg;
    assign result_item = out_reg;

    assign load   = !out_valid_reg || pop;
    assign at_end = (job_reg.nbytes == 2'd0) || (idx_reg == 2'(job_reg.nbytes - 2'd1));
    assign finish = job_valid_reg && load && at_end;
    assign q_pop  = !q_empty && (!job_valid_reg || finish);

    always_comb
    begin
        case (idx_reg)
            2'd0:    cur_byte = job_reg.word[23:16];
            2'd1:    cur_byte = job_reg.word[15:8];
            default: cur_byte = job_reg.word[7:0];
        endcase
        cur_item.has_data       = (job_reg.nbytes != 2'd0);
        cur_item.data_byte      = cur_item.has_data ? cur_byte : 8'd0;
        cur_item.last_of_string = job_reg.last && at_end;
        cur_item.stopped_early  = job_reg.stopped;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_data;
        end
        if (job_valid_reg && load)
        begin
            out_reg <= cur_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                job_valid_reg <= 1'b1;
                idx_reg       <= 2'd0;
            end
            else if (finish)
            begin
                job_valid_reg <= 1'b0;
            end
            else if (job_valid_reg && load)
            begin
                idx_reg <= 2'(idx_reg + 2'd1);
            end

            if (job_valid_reg && load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/base64_decoder_unit.sv
// Top level of the streaming base64 decoder.
//
// Input channel: one character per item (char_item), pushed with push while
// full is low. The end_of_string flag closes a string; the decoder then
// starts fresh for the next one.
// Result channel: one decoded byte per item (result_item), shown while empty
// is low and taken with pop. Each group of four valid characters yields three
// items; '=' or any non-alphabet character flushes the partial group and
// mutes the rest of the string. The end item always yields a final item with
// last_of_string set, an empty marker (has_data low) if it carries no byte.
// Path: a character's first result passes the job queue entry, the job register
// and the output register on its way to the result ports.
// Throughput: one character per cycle while full is low; the byte emitter
// sends one item per cycle while pop keeps up, so four characters (three
// bytes) never outrun it. When pop stalls, held jobs pile up in the job
// queue (QUEUE_DEPTH jobs) and full rises once it is full. Reset clears the
// group state, queue and output valid flag; no item is shown after reset.
`timescale 1ns / 1ps
module base64_decoder_unit #(
    parameter int unsigned QUEUE_DEPTH = b64d_pkg::JOB_QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  b64d_pkg::char_item_t   char_item,
    output logic                   empty,
    input  logic                   pop,
    output b64d_pkg::result_item_t result_item
);
    import b64d_pkg::*;

    // Jobs from the front end to the byte emitter.
    job_t job_in;
    job_t job_out;
    logic job_push;
    logic job_pop;
    logic q_full;
    logic q_empty;

    // Classify characters and assemble groups.
    b64d_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .char_item (char_item),
        .q_full    (q_full),
        .job_push  (job_push),
        .job       (job_in)
    );

    // Decouple the character stream from byte emission.
    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .q_full  (q_full),
        .rd_en   (job_pop),
        .rd_data (job_out),
        .q_empty (q_empty)
    );

    // Emit one item per cycle into the output register while pop keeps up.
    b64d_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (job_out),
        .q_pop       (job_pop),
        .pop         (pop),
        .empty       (empty),
        .result_item (result_item)
    );

endmodule

// File: verif/base64_decoder_unit_test.sv
// Self-checking testbench for the streaming base64 decoder unit.
`timescale 1ns / 1ps
module base64_decoder_unit_test;
    import b64d_pkg::*;

    // Stimulus length: directed strings first, then random strings until this many chars.
    localparam int unsigned TOTAL_CHARS  = 310;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned IDLE_PERCENT = 12;
    localparam logic [7:0]  PAD_CHAR     = 8'h3D;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         push = 1'b0;
    logic         pop = 1'b0;
    logic         full;
    logic         empty;
    char_item_t   char_item = '0;
    result_item_t result_item;

    base64_decoder_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .char_item   (char_item),
        .empty       (empty),
        .pop         (pop),
        .result_item (result_item)
    );

    always #5 clk = ~clk;

    // Characters waiting to be pushed, and decoded bytes waiting to come out.
    char_item_t   pending_chars[$];
    result_item_t expected_bytes[$];
    result_item_t step_out[$];

    // Predictor state: collected sextets, their count, and the stop flag of the string.
    logic [17:0] sextet_acc = '0;
    logic [1:0]  sextet_cnt = '0;
    logic        decode_halted = 1'b0;

    int unsigned errors = 0;
    int unsigned chars_taken = 0;
    int unsigned results_checked = 0;
    int unsigned strings_sent = 0;
    int unsigned early_stops = 0;
    bit          item_taken = 1'b0;
    bit          calm;
    result_item_t want;

    // A window of the run with no idling on either side.
    assign calm = (chars_taken >= 150) && (chars_taken < 230);

    // Classify a character: bit 6 flags anything outside the alphabet.
    function automatic logic [6:0] char_value(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
            return {1'b0, 6'(c - 8'd65)};
        if (c >= "a" && c <= "z")
            return {1'b0, 6'(c - 8'd71)};
        if (c >= "0" && c <= "9")
            return {1'b0, 6'(c + 8'd4)};
        if (c == "+")
            return 7'd62;
        if (c == "/")
            return 7'd63;
        return 7'h40;
    endfunction

    // Map a sextet back to its alphabet character for stimulus generation.
    function automatic logic [7:0] alpha_char(input logic [5:0] v);
        if (v < 6'd26)
            return 8'd65 + 8'(v);
        if (v < 6'd52)
            return 8'd71 + 8'(v);
        if (v < 6'd62)
            return 8'(v) - 8'd4;
        return (v == 6'd62) ? 8'h2B : 8'h2F;
    endfunction

    function automatic logic [7:0] random_invalid();
        logic [7:0] c;
        logic [6:0] cv;
        c  = 8'($urandom_range(0, 255));
        cv = char_value(c);
        while (!cv[6])
        begin
            c  = 8'($urandom_range(0, 255));
            cv = char_value(c);
        end
        return c;
    endfunction

    task automatic emit_byte(input logic [7:0] b);
        result_item_t r;
        r = '0;
        r.data_byte = b;
        r.has_data  = 1'b1;
        step_out.insert(step_out.size(), r);
    endtask

    // Flush a partial group: n sextets give n-1 bytes, a lone sextet gives none.
    task automatic flush_group();
        logic [23:0] w;
        if (sextet_cnt >= 2'd2)
        begin
            w = {6'b0, sextet_acc} << (6 * (4 - int'(sextet_cnt)));
            emit_byte(w[23:16]);
            if (sextet_cnt == 2'd3)
                emit_byte(w[15:8]);
        end
        sextet_acc = '0;
        sextet_cnt = '0;
    endtask

    // Work out the results of one accepted character and queue them.
    task automatic decode_char(input char_item_t it);
        logic [6:0]   cv;
        logic [23:0]  w;
        result_item_t marker;
        step_out.delete();
        if (!decode_halted)
        begin
            cv = char_value(it.char_code);
            if (!cv[6])
            begin
                if (sextet_cnt == 2'd3)
                begin
                    w = {sextet_acc, cv[5:0]};
                    emit_byte(w[23:16]);
                    emit_byte(w[15:8]);
                    emit_byte(w[7:0]);
                    sextet_acc = '0;
                    sextet_cnt = '0;
                end
                else
                begin
                    sextet_acc = {sextet_acc[11:0], cv[5:0]};
                    sextet_cnt = sextet_cnt + 2'd1;
                end
            end
            else
            begin
                flush_group();
                decode_halted = 1'b1;
            end
        end
        if (it.end_of_string)
        begin
            flush_group();
            if (step_out.size() == 0)
            begin
                marker = '0;
                step_out.insert(0, marker);
            end
            step_out[step_out.size() - 1].last_of_string = 1'b1;
        end
        foreach (step_out[k])
        begin
            step_out[k].stopped_early = decode_halted;
            expected_bytes.insert(expected_bytes.size(), step_out[k]);
        end
        if (it.end_of_string)
        begin
            if (decode_halted)
                early_stops++;
            decode_halted = 1'b0;
            sextet_acc    = '0;
            sextet_cnt    = '0;
        end
    endtask

    task automatic add_char(input logic [7:0] c, input logic eos);
        char_item_t it;
        it.char_code     = c;
        it.end_of_string = eos;
        pending_chars.insert(pending_chars.size(), it);
        if (eos)
            strings_sent++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i], i == s.len() - 1);
    endtask

    // One random string: mostly clean or padded base64, some cut by a bad char, some noise.
    task automatic add_random_string();
        logic [7:0] str[$];
        int shape;
        int nvalid;
        shape  = $urandom_range(0, 9);
        nvalid = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16) : $urandom_range(0, 9);
        if (shape < 8)
            for (int i = 0; i < nvalid; i++)
                str.insert(str.size(), alpha_char(6'($urandom_range(0, 63))));
        if (shape == 5 || shape == 6)
            repeat ($urandom_range(1, 2)) str.insert(str.size(), PAD_CHAR);
        if (shape == 7)
        begin
            str.insert(str.size(), random_invalid());
            repeat ($urandom_range(0, 4)) str.insert(str.size(), 8'($urandom_range(0, 255)));
        end
        if (shape >= 8)
            repeat ($urandom_range(1, 6)) str.insert(str.size(), 8'($urandom_range(0, 255)));
        if (str.size() == 0)
            str.insert(0, alpha_char(6'($urandom_range(0, 63))));
        foreach (str[i])
            add_char(str[i], i == str.size() - 1);
    endtask

    // Record each accepted character and predict what it yields.
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            decode_char(char_item);
            item_taken = 1'b1;
            chars_taken++;
        end
    end

    // Input driver: advance after an accepted item, hold a refused one, idle now and then.
    always @(negedge clk)
    begin : drive_chars
        bit taken;
        taken = item_taken;
        item_taken = 1'b0;
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (taken)
                pending_chars.delete(0);
            if (push && !taken)
            begin
                // hold the refused item until full drops
            end
            else if (pending_chars.size() != 0 &&
                     (calm || $urandom_range(0, 99) >= IDLE_PERCENT))
            begin
                push      <= 1'b1;
                char_item <= pending_chars[0];
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // Result side: stall pop at random outside the calm window.
    always @(negedge clk)
    begin
        pop <= rst_n && (calm || $urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Compare each popped result with the oldest predicted one.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected result item: data_byte 0x%02h has_data %0b last %0b stop %0b",
                       result_item.data_byte, result_item.has_data,
                       result_item.last_of_string, result_item.stopped_early);
                errors++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                results_checked++;
                if (result_item.data_byte !== want.data_byte)
                begin
                    $error("data_byte mismatch: expected 0x%02h, got 0x%02h",
                           want.data_byte, result_item.data_byte);
                    errors++;
                end
                if (result_item.has_data !== want.has_data)
                begin
                    $error("has_data mismatch: expected %0b, got %0b",
                           want.has_data, result_item.has_data);
                    errors++;
                end
                if (result_item.last_of_string !== want.last_of_string)
                begin
                    $error("last_of_string mismatch: expected %0b, got %0b",
                           want.last_of_string, result_item.last_of_string);
                    errors++;
                end
                if (result_item.stopped_early !== want.stopped_early)
                begin
                    $error("stopped_early mismatch: expected %0b, got %0b",
                           want.stopped_early, result_item.stopped_early);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int unsigned target;
        // Directed strings: a full group, every alphabet edge, flush of three and of
        // one sextet, pad then ignored chars, high codes, and a halted string.
        add_text("TWFu");
        add_text("/+90azAZ");
        add_text("QUI");
        add_text("A");
        add_char("Q", 1'b0);
        add_char("Q", 1'b0);
        add_char(PAD_CHAR, 1'b0);
        add_char("B", 1'b0);
        add_char(8'hFF, 1'b1);
        add_char(8'h80, 1'b1);
        add_char(8'h00, 1'b0);
        add_char(8'h7F, 1'b1);
        target = TOTAL_CHARS;
        while (pending_chars.size() < target)
            add_random_string();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Drain: every char taken and every predicted result popped.
        while (pending_chars.size() != 0 || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Decoded %0d strings from %0d characters; %0d stopped early.",
                 strings_sent, chars_taken, early_stops);
        $display("Checked %0d result items.", results_checked);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
